@@ rtl/core/msac_pkg.sv @@
// ----------------------------------------------------------------------------
// msac_pkg
// Shared types and constants for the multi-slot wakeup alarm clock.
// ----------------------------------------------------------------------------
package msac_pkg;

  localparam int ACT_W         = 3;
  localparam int SLOT_W        = 4;
  localparam int TIME_W        = 32;
  localparam int STAT_W        = 2;
  localparam int ACC_W         = 16;
  localparam int TICK_W        = 10;
  localparam int MASK_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int NUM_SLOTS_DEF = 8;

  localparam logic [TIME_W-1:0] NO_ALARM = {TIME_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK       = 3'd0,
    ACT_SET_REL    = 3'd1,
    ACT_SET_ABS    = 3'd2,
    ACT_ABORT      = 3'd3,
    ACT_SET_CLOCK  = 3'd4,
    ACT_CANCEL_ALL = 3'd5
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOT_OK  = 2'd1,
    ST_EARLIER = 2'd2,
    ST_PAST    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_MS_PER_SEC  = 2'd1,
    CFG_CLK_SET_EN  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_period_ms;
    logic [ACC_W-1:0]  ms_per_second;
    logic [MASK_W-1:0] clock_set_allowed;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_addr;
    logic              clr_all;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [TIME_W-1:0] current_time;
    logic [TIME_W-1:0] wakeup_time;
    logic              alarm_expired;
  } res_t;

endpackage

@@ rtl/core/multi_slot_wakeup_alarm_clock.sv @@
// ----------------------------------------------------------------------------
// multi_slot_wakeup_alarm_clock
// Seconds clock with a millisecond prescaler, per-slot alarms and a master
// alarm that tracks the earliest live slot.
// Sequence: actions that leave the slots alone go straight to the result;
//   set actions and expiring ticks rescan the slot memory for the master
//   alarm; an abort first reads its slot and rescans only if it was live.
// Throughput: one transaction in flight; the next is taken once the result
//   has moved to the output register, so the master-alarm scan over the slot
//   memory (one read per cycle) sets the rate.
// Reset: clock, prescaler, slots idle, master alarm all ones, registers 10,
//   1000 and 0; no clearing pass is needed, slots carry valid bits.
// ----------------------------------------------------------------------------
module multi_slot_wakeup_alarm_clock #(
  parameter int NUM_SLOTS = msac_pkg::NUM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [39:0]                         in_tdata,   // action[2:0], slot[6:3], time_value[38:7], zero pad
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [71:0]                         out_tdata,  // status[1:0], current_time[33:2],
                                                          // wakeup_time[65:34], alarm_expired[66], zero pad
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msac_pkg::CFG_DATA_W-1:0]     cfg_data
);

  msac_pkg::cfg_t      cfg_r, cfg_nxt;
  msac_pkg::mem_req_t  mem_req;
  msac_pkg::res_t      res;
  logic [msac_pkg::TIME_W-1:0] rd_data;
  logic                res_valid;
  logic                res_ready;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [71:0]         out_tdata_r;

  // Configuration writes: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (msac_pkg::cfg_idx_t'(cfg_index))
        msac_pkg::CFG_TICK_PERIOD: cfg_nxt.tick_period_ms    = cfg_data[msac_pkg::TICK_W-1:0];
        msac_pkg::CFG_MS_PER_SEC:  cfg_nxt.ms_per_second     = cfg_data[msac_pkg::ACC_W-1:0];
        msac_pkg::CFG_CLK_SET_EN:  cfg_nxt.clock_set_allowed = cfg_data[msac_pkg::MASK_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period_ms    <= msac_pkg::TICK_W'(10);
      cfg_r.ms_per_second     <= msac_pkg::ACC_W'(1000);
      cfg_r.clock_set_allowed <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Sequencer: decode, update clock, drive the slot memory.
  msac_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tdata[2:0]),
    .in_slot   (in_tdata[6:3]),
    .in_time   (in_tdata[38:7]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  msac_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: take a new result once the held one is gone or leaving,
  // so the sequencer is free again while the result waits downstream.
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload holds while stalled; load only on a handover.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {5'b0, res.alarm_expired, res.wakeup_time,
                      res.current_time, res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_tvalid_r)
    else $error("result handed over but output register not loaded");

endmodule

@@ rtl/core/msac_slot_mem.sv @@
// ----------------------------------------------------------------------------
// msac_slot_mem
// Alarm slot store: one 32-bit alarm time per slot, registered read, with a
// valid bit per slot so that an unwritten or cleared slot reads as idle
// (zero).
// ----------------------------------------------------------------------------
module msac_slot_mem #(
  parameter int NUM_SLOTS = msac_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msac_pkg::mem_req_t           req,
  output logic [msac_pkg::TIME_W-1:0]  rd_data
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [msac_pkg::TIME_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]        valid_r;
  logic [NUM_SLOTS-1:0]        valid_nxt;
  logic [msac_pkg::TIME_W-1:0] rd_q_r;
  logic                        rd_vld_r;

  always_comb begin
    valid_nxt = valid_r;
    if (req.clr_en) begin
      valid_nxt[req.clr_addr[AW-1:0]] = 1'b0;
    end
    if (req.wr_en) begin
      valid_nxt[req.wr_addr[AW-1:0]] = 1'b1;
    end
    if (req.clr_all) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    rd_q_r   <= mem[req.rd_addr[AW-1:0]];
    rd_vld_r <= valid_r[req.rd_addr[AW-1:0]];
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

  // a cancel-all leaves every slot idle
  a_clr_all: assert property (@(posedge clk) disable iff (!rst_n)
    req.clr_all |=> valid_r == '0)
    else $error("slot valid bits not cleared by cancel all");

endmodule

@@ rtl/core/msac_ctrl.sv @@
// ----------------------------------------------------------------------------
// msac_ctrl
// Action sequencer: decodes one transaction, updates clock and prescaler,
// writes the slot store and scans it to rebuild the master alarm.
// ----------------------------------------------------------------------------
module msac_ctrl #(
  parameter int NUM_SLOTS = msac_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msac_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [msac_pkg::ACT_W-1:0]   in_action,
  input  logic [msac_pkg::SLOT_W-1:0]  in_slot,
  input  logic [msac_pkg::TIME_W-1:0]  in_time,
  output msac_pkg::mem_req_t           mem_req,
  input  logic [msac_pkg::TIME_W-1:0]  rd_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output msac_pkg::res_t               res
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ABORT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [msac_pkg::TIME_W-1:0]        clk_r, clk_nxt;
  logic [msac_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic [msac_pkg::TIME_W-1:0]        master_r, master_nxt;
  msac_pkg::status_t                  status_r, status_nxt;
  logic                               expired_r, expired_nxt;
  logic [msac_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic                               purge_r, purge_nxt;
  logic [CW-1:0]                      idx_r, idx_nxt;
  logic [msac_pkg::TIME_W-1:0]        best_r, best_nxt;

  msac_pkg::action_t                  act;
  logic [msac_pkg::ACC_W:0]           tick_sum;
  logic [msac_pkg::TIME_W-1:0]        clk_inc;
  logic [msac_pkg::TIME_W-1:0]        when;
  logic                               slot_ok;
  logic [CW-1:0]                      idx_prev;
  logic                               scan_purge;
  logic [msac_pkg::TIME_W-1:0]        scan_best;

  assign act      = msac_pkg::action_t'(in_action);
  assign tick_sum = {1'b0, acc_r} + (msac_pkg::ACC_W+1)'(cfg.tick_period_ms);
  assign clk_inc  = clk_r + 1'b1;
  assign when     = (act == msac_pkg::ACT_SET_REL) ? (clk_r + in_time) : in_time;
  assign slot_ok  = {1'b0, in_slot} < (msac_pkg::SLOT_W+1)'(NUM_SLOTS);
  assign idx_prev = idx_r - 1'b1;

  // expired entries drop out on a purge scan; idle entries never count
  assign scan_purge = purge_r && (rd_data != '0) && (rd_data <= clk_r);
  assign scan_best  = (!scan_purge && (rd_data != '0) && (rd_data < best_r)) ?
                      rd_data : best_r;

  always_comb begin
    state_nxt   = state_r;
    clk_nxt     = clk_r;
    acc_nxt     = acc_r;
    master_nxt  = master_r;
    status_nxt  = status_r;
    expired_nxt = expired_r;
    slot_nxt    = slot_r;
    purge_nxt   = purge_r;
    idx_nxt     = idx_r;
    best_nxt    = best_r;
    mem_req     = '0;
    mem_req.rd_addr = slot_ok ? in_slot : '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt  = msac_pkg::ST_OK;
          expired_nxt = 1'b0;
          slot_nxt    = in_slot;
          purge_nxt   = 1'b0;
          idx_nxt     = '0;
          best_nxt    = msac_pkg::NO_ALARM;
          state_nxt   = S_DONE;
          unique case (act)
            msac_pkg::ACT_TICK: begin
              if (tick_sum >= {1'b0, cfg.ms_per_second}) begin
                acc_nxt = '0;
                clk_nxt = clk_inc;
                if (clk_inc >= master_r) begin
                  expired_nxt = 1'b1;
                  purge_nxt   = 1'b1;
                  state_nxt   = S_SCAN;
                end
              end else begin
                acc_nxt = tick_sum[msac_pkg::ACC_W-1:0];
              end
            end
            msac_pkg::ACT_SET_REL, msac_pkg::ACT_SET_ABS: begin
              if (!slot_ok) begin
                status_nxt = msac_pkg::ST_NOT_OK;
              end else if (act == msac_pkg::ACT_SET_ABS && in_time <= clk_r) begin
                status_nxt = msac_pkg::ST_PAST;
              end else begin
                status_nxt      = (when < master_r) ? msac_pkg::ST_OK : msac_pkg::ST_EARLIER;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = in_slot;
                mem_req.wr_data = when;
                state_nxt       = S_SCAN;
              end
            end
            msac_pkg::ACT_ABORT: begin
              if (!slot_ok) begin
                status_nxt = msac_pkg::ST_NOT_OK;
              end else begin
                state_nxt = S_ABORT;
              end
            end
            msac_pkg::ACT_SET_CLOCK: begin
              if (slot_ok && !in_slot[msac_pkg::SLOT_W-1] &&
                  cfg.clock_set_allowed[in_slot[msac_pkg::SLOT_W-2:0]]) begin
                clk_nxt = in_time;
              end
            end
            msac_pkg::ACT_CANCEL_ALL: begin
              mem_req.clr_all = 1'b1;
              master_nxt      = msac_pkg::NO_ALARM;
            end
            default: begin
              status_nxt = msac_pkg::ST_NOT_OK;
            end
          endcase
        end
      end
      S_ABORT: begin
        if (rd_data == '0) begin
          status_nxt = msac_pkg::ST_NOT_OK;
          state_nxt  = S_DONE;
        end else begin
          mem_req.clr_en   = 1'b1;
          mem_req.clr_addr = slot_r;
          state_nxt        = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_req.rd_addr = (idx_r < CW'(NUM_SLOTS)) ?
                          msac_pkg::SLOT_W'(idx_r[AW-1:0]) : '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r != '0) begin
          best_nxt = scan_best;
          if (scan_purge) begin
            mem_req.clr_en   = 1'b1;
            mem_req.clr_addr = msac_pkg::SLOT_W'(idx_prev[AW-1:0]);
          end
        end
        if (idx_r == CW'(NUM_SLOTS)) begin
          master_nxt = scan_best;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      clk_r    <= '0;
      acc_r    <= '0;
      master_r <= msac_pkg::NO_ALARM;
    end else begin
      state_r  <= state_nxt;
      clk_r    <= clk_nxt;
      acc_r    <= acc_nxt;
      master_r <= master_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    expired_r <= expired_nxt;
    slot_r    <= slot_nxt;
    purge_r   <= purge_nxt;
    idx_r     <= idx_nxt;
    best_r    <= best_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_DONE);
  assign res.status        = status_r;
  assign res.current_time  = clk_r;
  assign res.wakeup_time   = master_r;
  assign res.alarm_expired = expired_r;

  // master alarm is either a live slot time or all ones, never idle
  a_master_nz: assert property (@(posedge clk) disable iff (!rst_n)
    master_r != '0)
    else $error("master alarm holds the idle value");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= CW'(NUM_SLOTS)))
    else $error("slot scan ran past the last slot");

  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && act == msac_pkg::ACT_CANCEL_ALL) |=>
      (master_r == msac_pkg::NO_ALARM))
    else $error("cancel all left a master alarm");

endmodule
